@@ design/parch2_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// parch2_pkg
// Shared constants, types and helpers of the two-objective Pareto archive.
// ----------------------------------------------------------------------------
package parch2_pkg;

    localparam int unsigned CapacityDefault = 64;
    localparam int unsigned TagWidthDefault = 16;

    localparam int unsigned ObjW  = 32;
    localparam int unsigned TagW  = 16;
    localparam int unsigned CntW  = 7;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_DOM_REJ  = 3'd1;
    localparam logic [2:0] ST_FULL_REJ = 3'd2;
    localparam logic [2:0] ST_NOT_DOM  = 3'd3;
    localparam logic [2:0] ST_DOM      = 3'd4;
    localparam logic [2:0] ST_ENTRY    = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef struct packed {
        logic shift;
        logic keep;
        logic append;
    } t_cell_ctl;

    // a dominates b: no worse in both, strictly better in one
    function automatic logic dominates(input logic [ObjW-1:0] a1, input logic [ObjW-1:0] a2,
                                       input logic [ObjW-1:0] b1, input logic [ObjW-1:0] b2);
        return (a1 <= b1) && (a2 <= b2) && ((a1 < b1) || (a2 < b2));
    endfunction

endpackage
`default_nettype wire

@@ design/pareto_archive_two_objective_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pareto_archive_two_objective_core
// Exact non-dominated archive of two-objective points (smaller is better).
// ----------------------------------------------------------------------------
// Entries sit in a ring of CAPACITY cells; dominance checks at the head of the
// ring see each stored entry once per request while the ring rotates by one
// cell a cycle, and an insert drops entries the new point dominates. Busy
// stays high from the accepting edge through the scan and its final state;
// a new request is accepted only while busy is low. Insert and query give
// one result beat in the cycle after the scan ends; a read gives one beat per
// entry in storage order during the scan (or one empty beat). Result beats
// last one cycle and cannot be stalled. Request type 3 is ignored.
// ----------------------------------------------------------------------------
module pareto_archive_two_objective_core
    import parch2_pkg::*;
#(
    parameter int unsigned CAPACITY  = CapacityDefault,
    parameter int unsigned TAG_WIDTH = TagWidthDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [ObjW-1:0]    i_point_cost,
    input  wire logic [ObjW-1:0]    i_point_deprivation,
    input  wire logic [TagW-1:0]    i_point_tag,
    output logic                    o_strobe,
    output logic [2:0]              o_status,
    output logic [CntW-1:0]         o_removed_count,
    output logic [CntW-1:0]         o_count_after,
    output logic [ObjW-1:0]         o_entry_cost,
    output logic [ObjW-1:0]         o_entry_deprivation,
    output logic [TagW-1:0]         o_entry_tag,
    output logic                    o_last
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned TW = (TAG_WIDTH < TagW) ? TAG_WIDTH : TagW;
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_req, n_req;
    logic [ObjW-1:0]  r_pcost, n_pcost;
    logic [ObjW-1:0]  r_pdep, n_pdep;
    logic [TW-1:0]    r_ptag, n_ptag;
    logic [CW-1:0]    r_left, n_left;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_count_start, n_count_start;
    logic             r_dom, n_dom;

    logic             r_strobe, n_strobe;
    logic [2:0]       r_status, n_status;
    logic [CntW-1:0]  r_removed, n_removed;
    logic [CntW-1:0]  r_cnt_after, n_cnt_after;
    logic [ObjW-1:0]  r_ecost, n_ecost;
    logic [ObjW-1:0]  r_edep, n_edep;
    logic [TagW-1:0]  r_etag, n_etag;
    logic             r_last, n_last;

    logic [ObjW-1:0]  w_cost [CAPACITY];
    logic [ObjW-1:0]  w_dep  [CAPACITY];
    logic [TW-1:0]    w_tag  [CAPACITY];

    logic             w_accept;
    logic             w_step;
    logic             w_fin;
    logic             w_head_dom;
    logic             w_pt_dom;
    logic             w_keep;
    logic             w_append;
    t_cell_ctl        w_ctl;
    logic [CW-1:0]    w_removed;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy && (i_req_type != REQ_UNUSED);
    assign w_step   = (r_state == S_SCAN) && (r_left != '0);
    assign w_fin    = (r_state == S_SCAN) && (r_left == '0);

    assign w_head_dom = dominates(w_cost[0], w_dep[0], r_pcost, r_pdep);
    assign w_pt_dom   = dominates(r_pcost, r_pdep, w_cost[0], w_dep[0]);
    assign w_keep     = (r_req != REQ_INSERT) || !w_pt_dom;
    assign w_append   = w_fin && (r_req == REQ_INSERT) && !r_dom && (r_count != CapCount);
    assign w_removed  = r_count_start - r_count;

    assign w_ctl = '{shift: w_step, keep: w_keep, append: w_append};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int unsigned Nxt = (g + 1) % CAPACITY;
        parch2_cell #(
            .CAPACITY (CAPACITY),
            .TW       (TW),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_next_cost (w_cost[Nxt]),
            .i_next_dep  (w_dep[Nxt]),
            .i_next_tag  (w_tag[Nxt]),
            .i_head_cost (w_cost[0]),
            .i_head_dep  (w_dep[0]),
            .i_head_tag  (w_tag[0]),
            .i_new_cost  (r_pcost),
            .i_new_dep   (r_pdep),
            .i_new_tag   (r_ptag),
            .o_cost      (w_cost[g]),
            .o_dep       (w_dep[g]),
            .o_tag       (w_tag[g])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_pcost       = r_pcost;
        n_pdep        = r_pdep;
        n_ptag        = r_ptag;
        n_left        = r_left;
        n_count       = r_count;
        n_count_start = r_count_start;
        n_dom         = r_dom;
        n_strobe      = 1'b0;
        n_status      = r_status;
        n_removed     = '0;
        n_cnt_after   = CntW'(r_count);
        n_ecost       = '0;
        n_edep        = '0;
        n_etag        = '0;
        n_last        = 1'b1;

        if (w_accept) begin
            n_state       = S_SCAN;
            n_req         = i_req_type;
            n_pcost       = i_point_cost;
            n_pdep        = i_point_deprivation;
            n_ptag        = i_point_tag[TW-1:0];
            n_left        = r_count;
            n_count_start = r_count;
            n_dom         = 1'b0;
        end

        if (w_step) begin
            n_left = r_left - 1'b1;
            n_dom  = r_dom | w_head_dom;
            if (!w_keep) begin
                n_count = r_count - 1'b1;
            end
            if (r_req == REQ_READ) begin
                n_strobe = 1'b1;
                n_status = ST_ENTRY;
                n_ecost  = w_cost[0];
                n_edep   = w_dep[0];
                n_etag   = TagW'(w_tag[0]);
                n_last   = (r_left == CW'(1));
            end
        end

        if (w_fin) begin
            n_state = S_IDLE;
            unique case (r_req)
                REQ_INSERT: begin
                    n_strobe = 1'b1;
                    priority if (r_dom) begin
                        n_status = ST_DOM_REJ;
                    end else if (r_count == CapCount) begin
                        n_status = ST_FULL_REJ;
                    end else begin
                        n_status    = ST_ADDED;
                        n_removed   = CntW'(w_removed);
                        n_count     = r_count + 1'b1;
                        n_cnt_after = CntW'(r_count + 1'b1);
                    end
                end
                REQ_QUERY: begin
                    n_strobe = 1'b1;
                    n_status = r_dom ? ST_DOM : ST_NOT_DOM;
                end
                REQ_READ: begin
                    n_strobe = (r_count == '0);
                    n_status = ST_EMPTY;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_pcost       <= n_pcost;
        r_pdep        <= n_pdep;
        r_ptag        <= n_ptag;
        r_left        <= n_left;
        r_count_start <= n_count_start;
        r_dom         <= n_dom;
        r_status      <= n_status;
        r_removed     <= n_removed;
        r_cnt_after   <= n_cnt_after;
        r_ecost       <= n_ecost;
        r_edep        <= n_edep;
        r_etag        <= n_etag;
        r_last        <= n_last;
    end

    assign o_strobe            = r_strobe;
    assign o_status            = r_status;
    assign o_removed_count     = r_removed;
    assign o_count_after       = r_cnt_after;
    assign o_entry_cost        = r_ecost;
    assign o_entry_deprivation = r_edep;
    assign o_entry_tag         = r_etag;
    assign o_last              = r_last;

`ifndef ASSERT_OFF
    a_strobe_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_SCAN))
        else $error("result beat without a scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapCount)
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted request did not raise busy");

    a_removed_only_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_ADDED)) |-> (o_removed_count == '0))
        else $error("removed count on a non-insert beat");
`endif

endmodule
`default_nettype wire

@@ design/parch2_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// parch2_cell
// One archive slot. During a scan beat the slot takes its neighbor's entry,
// or the head entry, if kept, when it is the tail of the ring; on append it
// loads the new point when its index equals the entry count.
// ----------------------------------------------------------------------------
module parch2_cell
    import parch2_pkg::*;
#(
    parameter int unsigned CAPACITY = CapacityDefault,
    parameter int unsigned TW       = TagWidthDefault,
    parameter int unsigned IDX      = 0
) (
    input  wire logic                               i_clk,
    input  wire t_cell_ctl                          i_ctl,
    input  wire logic [$clog2(CAPACITY+1)-1:0]      i_count,
    input  wire logic [ObjW-1:0]                    i_next_cost,
    input  wire logic [ObjW-1:0]                    i_next_dep,
    input  wire logic [TW-1:0]                      i_next_tag,
    input  wire logic [ObjW-1:0]                    i_head_cost,
    input  wire logic [ObjW-1:0]                    i_head_dep,
    input  wire logic [TW-1:0]                      i_head_tag,
    input  wire logic [ObjW-1:0]                    i_new_cost,
    input  wire logic [ObjW-1:0]                    i_new_dep,
    input  wire logic [TW-1:0]                      i_new_tag,
    output logic [ObjW-1:0]                         o_cost,
    output logic [ObjW-1:0]                         o_dep,
    output logic [TW-1:0]                           o_tag
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] SelfIdx = CW'(IDX);
    localparam logic [CW-1:0] NextIdx = CW'(IDX + 1);

    logic [ObjW-1:0] r_cost, n_cost;
    logic [ObjW-1:0] r_dep,  n_dep;
    logic [TW-1:0]   r_tag,  n_tag;

    always_comb begin
        n_cost = r_cost;
        n_dep  = r_dep;
        n_tag  = r_tag;
        priority if (i_ctl.shift && (NextIdx == i_count) && i_ctl.keep) begin
            n_cost = i_head_cost;
            n_dep  = i_head_dep;
            n_tag  = i_head_tag;
        end else if (i_ctl.shift && (NextIdx < i_count)) begin
            n_cost = i_next_cost;
            n_dep  = i_next_dep;
            n_tag  = i_next_tag;
        end else if (i_ctl.append && (SelfIdx == i_count)) begin
            n_cost = i_new_cost;
            n_dep  = i_new_dep;
            n_tag  = i_new_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cost <= n_cost;
        r_dep  <= n_dep;
        r_tag  <= n_tag;
    end

    assign o_cost = r_cost;
    assign o_dep  = r_dep;
    assign o_tag  = r_tag;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-objective Pareto archive core.
// A scoreboard class keeps its own copy of the archive and works out the
// status, removal count, occupancy and read-out beats of every accepted
// request. Each result beat is compared field by field with the oldest
// expected beat. Stimulus starts with directed edge cases: empty reads,
// objective extremes, duplicates, multi-point removals and the ignored
// request code. Random traffic follows, mostly inserts and queries, many placed
// just around stored points. The run then fills the archive past capacity
// along a staircase front and clears it with the origin point. The sender
// idles at random rates that change from phase to phase.
// ----------------------------------------------------------------------------
module tb
    import parch2_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WatchdogLimit = 1000;
    localparam logic [ObjW-1:0] OBJ_MAX = '1;

    typedef struct {
        logic [2:0]      status;
        logic [CntW-1:0] removed;
        logic [CntW-1:0] count;
        logic [ObjW-1:0] cost;
        logic [ObjW-1:0] depr;
        logic [TagW-1:0] tag;
        logic            is_last;
    } t_beat;

    typedef enum int unsigned {
        NEAR_WORSE_COST,
        NEAR_WORSE_DEPR,
        NEAR_BETTER_COST,
        NEAR_BETTER_DEPR,
        NEAR_EQUAL
    } t_near;

    class archive_scoreboard;
        logic [ObjW-1:0] cost_mem [CapacityDefault];
        logic [ObjW-1:0] depr_mem [CapacityDefault];
        logic [TagW-1:0] tag_mem [CapacityDefault];
        int unsigned     n_entries = 0;
        t_beat           expected_q [$];
        int unsigned     n_errors = 0;
        int unsigned     n_requests = 0;
        int unsigned     n_beats = 0;
        int unsigned     n_full = 0;
        int unsigned     n_removed = 0;
        int unsigned     peak = 0;

        function bit covers(logic [ObjW-1:0] a1, logic [ObjW-1:0] a2,
                            logic [ObjW-1:0] b1, logic [ObjW-1:0] b2);
            return (a1 <= b1) && (a2 <= b2) && ((a1 < b1) || (a2 < b2));
        endfunction

        function void push_beat(logic [2:0] status, int unsigned removed,
                                logic [ObjW-1:0] cost, logic [ObjW-1:0] depr,
                                logic [TagW-1:0] tag, logic is_last);
            t_beat b;
            b.status  = status;
            b.removed = removed[CntW-1:0];
            b.count   = n_entries[CntW-1:0];
            b.cost    = cost;
            b.depr    = depr;
            b.tag     = tag;
            b.is_last = is_last;
            expected_q.insert(expected_q.size(), b);
        endfunction

        function void note_request(logic [1:0] req, logic [ObjW-1:0] c,
                                   logic [ObjW-1:0] d, logic [TagW-1:0] t);
            bit          dominated;
            int unsigned removed;
            int unsigned w;
            dominated = 0;
            removed = 0;
            w = 0;
            n_requests++;
            case (req)
                REQ_INSERT: begin
                    for (int i = 0; i < n_entries; i++) begin
                        if (covers(cost_mem[i], depr_mem[i], c, d)) dominated = 1;
                        if (covers(c, d, cost_mem[i], depr_mem[i])) removed++;
                    end
                    if (dominated) begin
                        push_beat(ST_DOM_REJ, 0, '0, '0, '0, 1'b1);
                    end else if (n_entries - removed >= CapacityDefault) begin
                        n_full++;
                        push_beat(ST_FULL_REJ, 0, '0, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < n_entries; i++) begin
                            if (!covers(c, d, cost_mem[i], depr_mem[i])) begin
                                cost_mem[w] = cost_mem[i];
                                depr_mem[w] = depr_mem[i];
                                tag_mem[w]  = tag_mem[i];
                                w++;
                            end
                        end
                        cost_mem[w] = c;
                        depr_mem[w] = d;
                        tag_mem[w]  = t;
                        n_entries = w + 1;
                        n_removed += removed;
                        if (n_entries > peak) peak = n_entries;
                        push_beat(ST_ADDED, removed, '0, '0, '0, 1'b1);
                    end
                end
                REQ_QUERY: begin
                    for (int i = 0; i < n_entries; i++) begin
                        if (covers(cost_mem[i], depr_mem[i], c, d)) dominated = 1;
                    end
                    push_beat(dominated ? ST_DOM : ST_NOT_DOM, 0, '0, '0, '0, 1'b1);
                end
                REQ_READ: begin
                    if (n_entries == 0) begin
                        push_beat(ST_EMPTY, 0, '0, '0, '0, 1'b1);
                    end
                    for (int i = 0; i < n_entries; i++) begin
                        push_beat(ST_ENTRY, 0, cost_mem[i], depr_mem[i], tag_mem[i],
                                  i + 1 == n_entries);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [ObjW-1:0] want,
                                    logic [ObjW-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            n_beats++;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: status %0d", got.status);
                n_errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", ObjW'(want.status), ObjW'(got.status));
            compare_field("removed_count", ObjW'(want.removed), ObjW'(got.removed));
            compare_field("count_after", ObjW'(want.count), ObjW'(got.count));
            compare_field("entry_cost", want.cost, got.cost);
            compare_field("entry_deprivation", want.depr, got.depr);
            compare_field("entry_tag", ObjW'(want.tag), ObjW'(got.tag));
            compare_field("last", ObjW'(want.is_last), ObjW'(got.is_last));
        endfunction

        function bit pick_stored(output logic [ObjW-1:0] c, output logic [ObjW-1:0] d);
            int unsigned k;
            c = '0;
            d = '0;
            if (n_entries == 0) return 0;
            k = $urandom_range(n_entries - 1);
            c = cost_mem[k];
            d = depr_mem[k];
            return 1;
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic [1:0]      i_req_type = REQ_INSERT;
    logic [ObjW-1:0] i_point_cost = '0;
    logic [ObjW-1:0] i_point_deprivation = '0;
    logic [TagW-1:0] i_point_tag = '0;
    logic            busy;
    logic            o_strobe;
    logic [2:0]      o_status;
    logic [CntW-1:0] o_removed_count;
    logic [CntW-1:0] o_count_after;
    logic [ObjW-1:0] o_entry_cost;
    logic [ObjW-1:0] o_entry_deprivation;
    logic [TagW-1:0] o_entry_tag;
    logic            o_last;

    archive_scoreboard sb = new();
    t_beat       seen_beat;
    int unsigned stall_cycles = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned items_sent = 0;

    pareto_archive_two_objective_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_req_type          (i_req_type),
        .i_point_cost        (i_point_cost),
        .i_point_deprivation (i_point_deprivation),
        .i_point_tag         (i_point_tag),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_removed_count     (o_removed_count),
        .o_count_after       (o_count_after),
        .o_entry_cost        (o_entry_cost),
        .o_entry_deprivation (o_entry_deprivation),
        .o_entry_tag         (o_entry_tag),
        .o_last              (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen_beat.status  = o_status;
            seen_beat.removed = o_removed_count;
            seen_beat.count   = o_count_after;
            seen_beat.cost    = o_entry_cost;
            seen_beat.depr    = o_entry_deprivation;
            seen_beat.tag     = o_entry_tag;
            seen_beat.is_last = o_last;
            sb.check_beat(seen_beat);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WatchdogLimit) begin
            $display("watchdog: %0d cycles without a beat", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called just after a rising edge; returns at the edge that takes the beat
    task automatic send_request(input logic [1:0] req, input logic [ObjW-1:0] c,
                                input logic [ObjW-1:0] d, input logic [TagW-1:0] t);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start               <= 1'b1;
        i_req_type          <= req;
        i_point_cost        <= c;
        i_point_deprivation <= d;
        i_point_tag         <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(req, c, d, t);
        items_sent++;
    endtask

    task automatic probe_near(input bit as_query);
        logic [ObjW-1:0] c;
        logic [ObjW-1:0] d;
        logic [ObjW-1:0] step;
        t_near           mode;
        if (!sb.pick_stored(c, d)) begin
            send_request(as_query ? REQ_QUERY : REQ_INSERT, $urandom, $urandom,
                         TagW'($urandom));
            return;
        end
        mode = t_near'($urandom_range(4));
        step = ($urandom_range(3) == 0) ? $urandom_range(1, 32'h0010_0000)
                                        : $urandom_range(1, 4);
        case (mode)
            NEAR_WORSE_COST:  if (c <= OBJ_MAX - step) c = c + step;
            NEAR_WORSE_DEPR:  if (d <= OBJ_MAX - step) d = d + step;
            NEAR_BETTER_COST: if (c >= step) c = c - step;
            NEAR_BETTER_DEPR: if (d >= step) d = d - step;
            default: begin
            end
        endcase
        send_request(as_query ? REQ_QUERY : REQ_INSERT, c, d, TagW'($urandom));
    endtask

    task automatic insert_staircase(input int unsigned n, input logic [ObjW-1:0] cost0,
                                    input logic [ObjW-1:0] depr0,
                                    input logic [ObjW-1:0] step_max);
        logic [ObjW-1:0] c;
        logic [ObjW-1:0] d;
        c = cost0;
        d = depr0;
        for (int k = 0; k < n; k++) begin
            send_request(REQ_INSERT, c, d, TagW'($urandom));
            c = c + $urandom_range(1, step_max);
            d = d - $urandom_range(1, step_max);
        end
    endtask

    task automatic run_mixed(input int unsigned target);
        int unsigned pick;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                probe_near(pick < 12);
            end else if (pick < 55) begin
                insert_staircase($urandom_range(3, 8),
                                 $urandom_range(32'h1000_0000, 32'hBFFF_FFFF),
                                 $urandom_range(32'h4000_0000, 32'hFFFF_FFFF),
                                 $urandom_range(1, 32'h0100_0000));
            end else if (pick < 70) begin
                send_request(pick < 63 ? REQ_INSERT : REQ_QUERY, $urandom, $urandom,
                             TagW'($urandom));
            end else if (pick < 82) begin
                send_request(REQ_READ, $urandom, $urandom, TagW'($urandom));
            end else if (pick < 86) begin
                send_request(REQ_UNUSED, $urandom, $urandom, TagW'($urandom));
            end else begin
                probe_near(1'b0);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 24;
        send_request(REQ_READ, '0, '0, '0);
        send_request(REQ_QUERY, '0, '0, '0);
        send_request(REQ_INSERT, '0, OBJ_MAX, '0);
        send_request(REQ_INSERT, OBJ_MAX, '0, 16'hFFFF);
        send_request(REQ_INSERT, OBJ_MAX, OBJ_MAX, 16'hA5A5);
        send_request(REQ_QUERY, OBJ_MAX, OBJ_MAX, '0);
        send_request(REQ_QUERY, '0, '0, '0);
        send_request(REQ_INSERT, '0, OBJ_MAX, 16'h1234);
        send_request(REQ_INSERT, 32'd1000, 32'd2000, 16'h0001);
        send_request(REQ_INSERT, 32'd2000, 32'd1000, 16'h0002);
        send_request(REQ_INSERT, 32'd1500, 32'd1500, 16'h0003);
        send_request(REQ_INSERT, 32'd1000, 32'd2000, 16'h0004);
        send_request(REQ_READ, '0, '0, '0);
        send_request(REQ_INSERT, 32'd999, 32'd1000, 16'h0005);
        send_request(REQ_QUERY, 32'd999, 32'd1000, '0);
        send_request(REQ_QUERY, 32'd1000, 32'd1000, '0);
        send_request(REQ_UNUSED, OBJ_MAX, OBJ_MAX, 16'hFFFF);
        send_request(REQ_INSERT, 32'd998, 32'd1001, 16'h0006);
        send_request(REQ_INSERT, '0, OBJ_MAX - 1, 16'h0007);
        send_request(REQ_READ, '0, '0, '0);

        run_mixed(items_sent + 35);
        sender_idle_pct = 56;
        run_mixed(items_sent + 35);

        // tight staircase near the origin overruns capacity
        sender_idle_pct = 0;
        insert_staircase(69, 32'd1, 32'd69, 32'd1);
        repeat (6) probe_near(1'($urandom_range(1)));
        send_request(REQ_READ, '0, '0, '0);

        // the origin clears everything and then only duplicates of it survive
        send_request(REQ_INSERT, '0, '0, 16'hBEEF);
        send_request(REQ_INSERT, '0, '0, 16'h4110);
        send_request(REQ_INSERT, '0, 32'd1, 16'h0008);
        send_request(REQ_QUERY, '0, '0, '0);
        send_request(REQ_READ, '0, '0, '0);
        start <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("covered %0d requests and %0d result beats, peak occupancy %0d of %0d",
                 sb.n_requests, sb.n_beats, sb.peak, CapacityDefault);
        $display("full-archive refusals %0d, points swept out by inserts %0d",
                 sb.n_full, sb.n_removed);
        if (sb.n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
